@@ sv/biou_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box iou package
// widths and types shared by the center-format box iou pipeline
// ----------------------------------------------------------------------------
package biou_pkg;

    localparam int COORD_BITS    = 16;
    localparam int IOU_FRAC_BITS = 16;

    // edges at double scale: 2*center +/- size
    localparam int EDGE_W   = COORD_BITS + 2;
    // signed overlap, one more bit than an edge
    localparam int OVL_W    = COORD_BITS + 3;
    // non-negative overlap is at most twice a size
    localparam int OVLU_W   = COORD_BITS + 1;
    localparam int PROD_W   = 2 * OVLU_W;
    localparam int AREA_W   = 2 * COORD_BITS;
    localparam int INTER_W  = 2 * COORD_BITS;
    localparam int UNION_W  = 2 * COORD_BITS + 1;
    localparam int IOU_W    = IOU_FRAC_BITS + 1;

    // pipeline: edges, overlaps, products, union, divide setup, then one
    // quotient bit per stage
    localparam int PRE_STAGES = 5;
    localparam int NUM_STAGES = PRE_STAGES + IOU_FRAC_BITS;

    localparam int IN_DATA_W      = 8 * COORD_BITS;
    localparam int OUT_FIELDS_W   = IOU_W + INTER_W + UNION_W;
    localparam int OUT_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-1:0] size_t;
    typedef logic signed [EDGE_W-1:0]     edge_t;
    typedef logic signed [OVL_W-1:0]      ovl_t;
    typedef logic        [OVLU_W-1:0]     ovlu_t;
    typedef logic        [AREA_W-1:0]     area_t;
    typedef logic        [INTER_W-1:0]    inter_t;
    typedef logic        [UNION_W-1:0]    union_t;
    typedef logic        [IOU_FRAC_BITS-1:0] quot_t;

endpackage

@@ sv/box_iou_center_format.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box iou, center format
// intersection over union of two axis-aligned boxes, unless stalled, one pair per cycle
// ----------------------------------------------------------------------------
// Takes a pair of boxes (center x/y signed, width/height unsigned, 4 fraction
// bits) and returns intersection area, union area (8 fraction bits) and their
// ratio as an unsigned 16-fraction-bit value where 0x10000 means 1.0. A new
// pair can be accepted every cycle unless every stage is full. The pipe has
// 21 register stages: five stages of geometry (edges, overlaps and areas,
// intersection product, union, divide setup), then a restoring divider
// that resolves one quotient bit per stage. Each stage holds its own valid
// bit and a stalled stage only blocks the stages behind it, so bubbles
// collapse and the input keeps accepting while a finished result waits at
// the output, until every stage is full. Ratio is truncated, zero for an
// empty union, and exactly 1.0 on full overlap. The block keeps no state
// between items.
module box_iou_center_format (
    input  logic                          aclk,
    input  logic                          aresetn,
    // a_center_x, a_center_y, a_width, a_height,
    // b_center_x, b_center_y, b_width, b_height (16 bits each, lowest first)
    input  logic [biou_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // iou_fraction [16:0], intersect_area [48:17], uni_area [81:49],
    // zero padding above
    output logic [biou_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready
);
    import biou_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int N  = IOU_FRAC_BITS;
    // stage index of the divide setup
    localparam int SETUP = PRE_STAGES - 1;

    // per-stage valid bits and the ready chain feeding back from the output
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES:0]   rdy;

    // input fields
    coord_t acx, acy, bcx, bcy;
    size_t  aw, ah, bw, bh;

    // stage 1: double-scale edges per axis
    edge_t  rx_reg, lx_reg, ry_reg, ly_reg;
    edge_t  rx_next, lx_next, ry_next, ly_next;
    size_t  s1_aw_reg, s1_ah_reg, s1_bw_reg, s1_bh_reg;

    // stage 2: overlaps and box areas
    ovlu_t  ox_reg, oy_reg;
    logic   empty_reg;
    area_t  area_a_reg, area_b_reg;
    ovl_t   ox_s, oy_s;

    // stage 3: intersection and area sum
    inter_t s3_inter_reg;
    union_t sum_reg;
    logic [PROD_W-1:0] prod;

    // stage 4: union
    inter_t s4_inter_reg;
    union_t s4_union_reg;

    // divide stages, index 0 is the setup stage
    union_t dv_rem_reg   [0:N];
    union_t dv_den_reg   [0:N];
    inter_t dv_inter_reg [0:N];
    quot_t  dv_q_reg     [0:N];
    logic   dv_skip_reg  [0:N];
    logic   dv_full_reg  [0:N];
    logic   ge_setup;

    assign acx = coord_t'(s_axis_tdata[0*CB +: CB]);
    assign acy = coord_t'(s_axis_tdata[1*CB +: CB]);
    assign aw  = s_axis_tdata[2*CB +: CB];
    assign ah  = s_axis_tdata[3*CB +: CB];
    assign bcx = coord_t'(s_axis_tdata[4*CB +: CB]);
    assign bcy = coord_t'(s_axis_tdata[5*CB +: CB]);
    assign bw  = s_axis_tdata[6*CB +: CB];
    assign bh  = s_axis_tdata[7*CB +: CB];

    // a stage may load when it is empty or its contents move on;
    // resolved from the output end back to the input
    always_comb begin
        rdy[NUM_STAGES] = m_axis_tready;
        for (int i = NUM_STAGES - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_axis_tready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // ---- stage 1: edges, smaller right edge and larger left edge ----
    always_comb begin
        edge_t la, ra, lb, rb, ta, tb, ua, ub;
        la = $signed({acx[CB-1], acx, 1'b0}) - $signed({2'b00, aw});
        ra = $signed({acx[CB-1], acx, 1'b0}) + $signed({2'b00, aw});
        lb = $signed({bcx[CB-1], bcx, 1'b0}) - $signed({2'b00, bw});
        rb = $signed({bcx[CB-1], bcx, 1'b0}) + $signed({2'b00, bw});
        ta = $signed({acy[CB-1], acy, 1'b0}) - $signed({2'b00, ah});
        ua = $signed({acy[CB-1], acy, 1'b0}) + $signed({2'b00, ah});
        tb = $signed({bcy[CB-1], bcy, 1'b0}) - $signed({2'b00, bh});
        ub = $signed({bcy[CB-1], bcy, 1'b0}) + $signed({2'b00, bh});
        rx_next = (ra < rb) ? ra : rb;
        lx_next = (la > lb) ? la : lb;
        ry_next = (ua < ub) ? ua : ub;
        ly_next = (ta > tb) ? ta : tb;
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && s_axis_tvalid) begin
            rx_reg    <= rx_next;
            lx_reg    <= lx_next;
            ry_reg    <= ry_next;
            ly_reg    <= ly_next;
            s1_aw_reg <= aw;
            s1_ah_reg <= ah;
            s1_bw_reg <= bw;
            s1_bh_reg <= bh;
        end
    end

    // ---- stage 2: overlaps at double scale, box areas ----
    assign ox_s = $signed({rx_reg[EDGE_W-1], rx_reg}) - $signed({lx_reg[EDGE_W-1], lx_reg});
    assign oy_s = $signed({ry_reg[EDGE_W-1], ry_reg}) - $signed({ly_reg[EDGE_W-1], ly_reg});

    always_ff @(posedge aclk) begin
        if (rdy[1] && vld_reg[0]) begin
            // a non-negative overlap never exceeds twice a size
            ox_reg     <= ox_s[OVLU_W-1:0];
            oy_reg     <= oy_s[OVLU_W-1:0];
            empty_reg  <= ox_s[OVL_W-1] || oy_s[OVL_W-1];
            area_a_reg <= AREA_W'(s1_aw_reg) * AREA_W'(s1_ah_reg);
            area_b_reg <= AREA_W'(s1_bw_reg) * AREA_W'(s1_bh_reg);
        end
    end

    // ---- stage 3: intersection is the double-scale product over four ----
    assign prod = PROD_W'(ox_reg) * PROD_W'(oy_reg);

    always_ff @(posedge aclk) begin
        if (rdy[2] && vld_reg[1]) begin
            s3_inter_reg <= empty_reg ? '0 : prod[PROD_W-1:2];
            sum_reg      <= UNION_W'(area_a_reg) + UNION_W'(area_b_reg);
        end
    end

    // ---- stage 4: union, never negative since each overlap fits its box ----
    always_ff @(posedge aclk) begin
        if (rdy[3] && vld_reg[2]) begin
            s4_inter_reg <= s3_inter_reg;
            s4_union_reg <= sum_reg - UNION_W'(s3_inter_reg);
        end
    end

    // ---- stage 5: divide setup ----
    // empty union or full overlap bypass the divider: quotient bits stay zero
    assign ge_setup = UNION_W'(s4_inter_reg) >= s4_union_reg;

    always_ff @(posedge aclk) begin
        if (rdy[SETUP] && vld_reg[SETUP-1]) begin
            dv_skip_reg[0]  <= (s4_union_reg == '0) || ge_setup;
            dv_full_reg[0]  <= (s4_union_reg != '0) && ge_setup;
            dv_rem_reg[0]   <= ((s4_union_reg == '0) || ge_setup) ? '0
                                                                  : UNION_W'(s4_inter_reg);
            dv_den_reg[0]   <= s4_union_reg;
            dv_inter_reg[0] <= s4_inter_reg;
            dv_q_reg[0]     <= '0;
        end
    end

    // ---- restoring divider, one quotient bit per stage ----
    for (genvar k = 1; k <= N; k++) begin : g_div
        logic [UNION_W:0] rem_sh;
        logic             take;

        assign rem_sh = {dv_rem_reg[k-1], 1'b0};
        assign take   = !dv_skip_reg[k-1] && (rem_sh >= {1'b0, dv_den_reg[k-1]});

        always_ff @(posedge aclk) begin
            if (rdy[SETUP+k] && vld_reg[SETUP+k-1]) begin
                // remainder stays below the divisor, so the top bit drops
                dv_rem_reg[k]   <= take ? UNION_W'(rem_sh - {1'b0, dv_den_reg[k-1]})
                                        : UNION_W'(rem_sh);
                dv_q_reg[k]     <= {dv_q_reg[k-1][N-2:0], take};
                dv_den_reg[k]   <= dv_den_reg[k-1];
                dv_inter_reg[k] <= dv_inter_reg[k-1];
                dv_skip_reg[k]  <= dv_skip_reg[k-1];
                dv_full_reg[k]  <= dv_full_reg[k-1];
            end
        end
    end

    // full overlap sets the 1.0 bit above an all-zero quotient
    assign m_axis_tvalid = vld_reg[NUM_STAGES-1];
    assign m_axis_tdata  = OUT_DATA_W'({dv_den_reg[N], dv_inter_reg[N],
                                        dv_full_reg[N], dv_q_reg[N]});

    // ---- checks ----
    a_inter_le_union: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> UNION_W'(dv_inter_reg[N]) <= dv_den_reg[N])
        else $error("intersection above union");

    a_empty_union_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && dv_den_reg[N] == '0) |-> (!dv_full_reg[N] && dv_q_reg[N] == '0))
        else $error("nonzero ratio on empty union");

    a_full_is_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && dv_full_reg[N]) |->
            (dv_q_reg[N] == '0 && UNION_W'(dv_inter_reg[N]) == dv_den_reg[N]))
        else $error("full ratio without full overlap");

    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (&vld_reg))
        else $error("input stalled with an empty stage");

endmodule

@@ tb/sv/tb_box_iou_center_format.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box iou center format testbench
// streams box pairs through the iou pipeline and checks every result item
// against an in-bench predictor of edges, overlaps, areas and the ratio.
// a directed set covers extremes and corner geometry, then random pairs
// (mostly overlapping ones) run under four idle/stall phases
// ----------------------------------------------------------------------------
module tb_box_iou_center_format;

    import biou_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_CYC   = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 200;
    localparam int DRAIN_CYC   = NUM_STAGES + 8;
    localparam int PAD_W       = OUT_DATA_W - OUT_FIELDS_W;

    // field order in s_axis_tdata: a_cx lowest, b_h highest
    typedef struct packed {
        size_t  b_h;
        size_t  b_w;
        coord_t b_cy;
        coord_t b_cx;
        size_t  a_h;
        size_t  a_w;
        coord_t a_cy;
        coord_t a_cx;
    } box_pair_t;

    typedef struct {
        logic [IOU_W-1:0]   iou_fraction;
        logic [INTER_W-1:0] intersect_area;
        logic [UNION_W-1:0] uni_area;
    } iou_result_t;

    // ------------------------------------------------------------------------
    // clock, reset and block hookup
    // ------------------------------------------------------------------------
    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    box_iou_center_format dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    box_pair_t   pending_pairs[$];   // items waiting for the driver
    iou_result_t iou_expected[$];    // predictions for accepted items, oldest first
    box_pair_t   pair_on_bus;        // item currently offered on s_axis
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          n_loaded       = 0;
    int          n_accepted     = 0;
    int          n_results      = 0;
    int          n_directed     = 0;
    int          n_errors       = 0;
    int          cycle_count    = 0;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // overlap at double scale along one axis; negative when the boxes miss
    function automatic longint axis_overlap_x2(coord_t ca, size_t wa, coord_t cb, size_t wb);
        longint la, ra, lb, rb;
        la = 2 * longint'(ca) - longint'(wa);
        ra = 2 * longint'(ca) + longint'(wa);
        lb = 2 * longint'(cb) - longint'(wb);
        rb = 2 * longint'(cb) + longint'(wb);
        return ((ra < rb) ? ra : rb) - ((la > lb) ? la : lb);
    endfunction

    function automatic iou_result_t predict_iou(box_pair_t p);
        longint      ox, oy, inter, uni;
        iou_result_t r;
        ox = axis_overlap_x2(p.a_cx, p.a_w, p.b_cx, p.b_w);
        oy = axis_overlap_x2(p.a_cy, p.a_h, p.b_cy, p.b_h);
        // both overlaps are at double scale, so the product is four times the area
        inter = 0;
        if (ox >= 0 && oy >= 0) begin
            inter = (ox * oy) >>> 2;
        end
        uni = longint'(p.a_w) * longint'(p.a_h) + longint'(p.b_w) * longint'(p.b_h) - inter;
        // truncated ratio, zero on empty union, pinned at 1.0 on full overlap
        if (uni <= 0) begin
            r.iou_fraction = '0;
        end else if (inter >= uni) begin
            r.iou_fraction = IOU_W'(longint'(1) << IOU_FRAC_BITS);
        end else begin
            r.iou_fraction = IOU_W'((inter << IOU_FRAC_BITS) / uni);
        end
        r.intersect_area = INTER_W'(inter);
        r.uni_area       = UNION_W'(uni);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic box_pair_t make_pair(int acx, int acy, int aw, int ah,
                                            int bcx, int bcy, int bw, int bh);
        box_pair_t p;
        p.a_cx = coord_t'(acx);
        p.a_cy = coord_t'(acy);
        p.a_w  = size_t'(aw);
        p.a_h  = size_t'(ah);
        p.b_cx = coord_t'(bcx);
        p.b_cy = coord_t'(bcy);
        p.b_w  = size_t'(bw);
        p.b_h  = size_t'(bh);
        return p;
    endfunction

    // size with a random bit length, so small and huge boxes both show up
    function automatic size_t rand_size();
        int nbits;
        nbits = $urandom_range(0, COORD_BITS);
        return size_t'($urandom & ((32'd1 << nbits) - 1));
    endfunction

    // center offset that lands near or inside the other box's extent
    function automatic coord_t near_offset(size_t w);
        int span;
        span = int'(w) + 2;
        return coord_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic push_pair(box_pair_t p);
        pending_pairs.push_back(p);
        n_loaded++;
    endtask

    task automatic load_directed();
        box_pair_t d[$];
        d.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));                     // empty union
        d.push_back(make_pair(0, 0, 16, 16, 0, 0, 16, 16));                 // identical boxes
        d.push_back(make_pair(32767, 32767, 65535, 65535,
                              32767, 32767, 65535, 65535));                 // largest full overlap
        d.push_back(make_pair(-32768, -32768, 65535, 65535,
                              32767, 32767, 65535, 65535));                 // opposite corners
        d.push_back(make_pair(0, 0, 32, 32, 32, 0, 32, 32));                // edges touch in x
        d.push_back(make_pair(0, 0, 32, 32, 0, -32, 32, 32));               // edges touch in y
        d.push_back(make_pair(0, 0, 16, 16, 100, 100, 16, 16));             // disjoint
        d.push_back(make_pair(0, 0, 3, 3, 1, 1, 2, 2));                     // half-step overlap
        d.push_back(make_pair(0, 0, 3, 5, 1, 0, 2, 2));                     // half step, one axis
        d.push_back(make_pair(0, 0, 64, 64, 0, 0, 16, 16));                 // b inside a
        d.push_back(make_pair(0, 0, 0, 0, 0, 0, 32, 32));                   // point inside box
        d.push_back(make_pair(5, 5, 0, 100, 5, 5, 0, 50));                  // zero-width pair
        d.push_back(make_pair(-32768, 0, 65535, 16, -32768, 0, 65535, 16)); // wide at left edge
        d.push_back(make_pair(0, 0, 48, 16, 8, 0, 48, 16));                 // ratio truncates
        d.push_back(make_pair(0, 0, 65535, 1, 0, 0, 1, 65535));             // crossing slivers
        d.push_back(make_pair(-32768, -32768, 4, 4, 32767, 32767, 4, 4));   // tiny far apart
        d.push_back(make_pair(-1, -1, 65535, 65535, -1, -1, 65535, 65535)); // all-ones fields
        d.push_back(make_pair(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                              16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));     // checkerboard bits
        d.push_back(make_pair(0, 0, 1000, 1000, 1, 0, 1000, 1000));         // just under 1.0
        d.push_back(make_pair(100, 100, 1, 1, 100, 100, 1, 1));             // one-step boxes
        foreach (d[i]) begin
            push_pair(d[i]);
        end
        n_directed += d.size();
    endtask

    // mostly pairs that overlap or nearly so; the rest is raw random bits
    task automatic load_random(int n);
        box_pair_t p;
        int        kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 99);
            p = box_pair_t'({$urandom, $urandom, $urandom, $urandom});
            if (kind < 85) begin
                p.a_w  = rand_size();
                p.a_h  = rand_size();
                p.b_w  = rand_size();
                p.b_h  = rand_size();
                p.b_cx = p.a_cx + near_offset(p.a_w);
                p.b_cy = p.a_cy + near_offset(p.a_h);
            end
            if (kind >= 55 && kind < 65) begin
                // same box twice
                p.b_cx = p.a_cx;
                p.b_cy = p.a_cy;
                p.b_w  = p.a_w;
                p.b_h  = p.a_h;
            end else if (kind >= 65 && kind < 75) begin
                // one side of one box collapsed to zero
                case ($urandom_range(0, 3))
                    0: p.a_w = '0;
                    1: p.a_h = '0;
                    2: p.b_w = '0;
                    default: p.b_h = '0;
                endcase
            end else if (kind >= 75 && kind < 85) begin
                // right edge of a meets left edge of b
                p.b_w[0] = p.a_w[0];
                p.b_cx   = p.a_cx + coord_t'((int'(p.a_w) + int'(p.b_w)) / 2);
            end
            push_pair(p);
        end
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // driver: offers the next pending item, predicts on every accept
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                iou_expected.push_back(predict_iou(pair_on_bus));
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    pair_on_bus = pending_pairs.pop_front();
                    s_axis_tdata  <= pair_on_bus;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random back-pressure, compares each result with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        iou_result_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (iou_expected.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, actual %0h",
                             $time, m_axis_tdata);
                    n_errors++;
                end else begin
                    want = iou_expected.pop_front();
                    check_field("iou_fraction", want.iou_fraction, m_axis_tdata[IOU_W-1:0]);
                    check_field("intersect_area", want.intersect_area,
                                m_axis_tdata[IOU_W +: INTER_W]);
                    check_field("uni_area", want.uni_area,
                                m_axis_tdata[IOU_W + INTER_W +: UNION_W]);
                    check_field("padding", '0, m_axis_tdata[OUT_DATA_W-1 -: PAD_W]);
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d predictions still open",
                     cycle_count, iou_expected.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence: reset, then four idle/stall phases with a full drain between
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            if (ph == 0) begin
                load_directed();
            end
            load_random(PHASE_ITEMS);
            // sender holds off here until every prediction has been matched
            while (n_accepted < n_loaded || iou_expected.size() != 0) begin
                @(posedge aclk);
            end
        end
        // catch any stray result still coming out of the pipe
        repeat (DRAIN_CYC) @(posedge aclk);
        $display("covered %0d box pairs (%0d directed corner cases, rest random)",
                 n_accepted, n_directed);
        $display("checked %0d result items over four idle and back-pressure phases, %0d errors",
                 n_results, n_errors);
        if (n_errors == 0 && iou_expected.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/biou_pkg.sv
sv/box_iou_center_format.sv
tb/sv/tb_box_iou_center_format.sv
